@@ rtl/sfd_pkg.sv @@
// Shared types and constants for the serial frame deframer.
`timescale 1ns / 1ps
package sfd_pkg;

	// Number of bytes in the little-endian length field (1 or 2).
	localparam int unsigned LEN_BYTES = 2;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned LEFT_W   = 17;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// Byte role codes.
	localparam logic [CODE_W-1:0] ROLE_DISCARD = 3'd0;
	localparam logic [CODE_W-1:0] ROLE_HEADER  = 3'd1;
	localparam logic [CODE_W-1:0] ROLE_LENGTH  = 3'd2;
	localparam logic [CODE_W-1:0] ROLE_TYPE    = 3'd3;
	localparam logic [CODE_W-1:0] ROLE_PAYLOAD = 3'd4;
	localparam logic [CODE_W-1:0] ROLE_FOOTER  = 3'd5;

	// Frame status codes.
	localparam logic [CODE_W-1:0] STAT_NONE       = 3'd0;
	localparam logic [CODE_W-1:0] STAT_GOOD       = 3'd1;
	localparam logic [CODE_W-1:0] STAT_BAD_FOOTER = 3'd2;
	localparam logic [CODE_W-1:0] STAT_BAD_TYPE   = 3'd3;
	localparam logic [CODE_W-1:0] STAT_TOO_LONG   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] header_value;
		logic [BYTE_W-1:0] footer_value;
		logic [BYTE_W-1:0] type_limit;
		logic [LEN_W-1:0]  max_payload;
	} sfd_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [CODE_W-1:0] byte_role;
		logic [BYTE_W-1:0] frame_kind;
		logic [LEN_W-1:0]  payload_size;
		logic [LEFT_W-1:0] bytes_to_go;
		logic              frame_end;
		logic [CODE_W-1:0] frame_status;
	} sfd_result_t;

endpackage

@@ rtl/serial_frame_deframer.sv @@
// Top level of the serial frame deframer.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | rx_byte
//   out     | out_valid / out_ready| data_byte, byte_role, frame_kind,
//           |                      | payload_size, bytes_to_go, frame_end,
//           |                      | frame_status
//   cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One byte is accepted per cycle while the output is not stalled; each byte yields one result
// through the input register, then the result register after the frame tracker logic.
// Reset clears the frame state and loads register defaults; no clearing pass.
// A stalled output holds its result; the input register still takes one more byte,
// after which in_ready drops until the result transaction completes.
`timescale 1ns / 1ps
module serial_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sfd_pkg::BYTE_W-1:0]    data_byte,
	output logic [sfd_pkg::CODE_W-1:0]    byte_role,
	output logic [sfd_pkg::BYTE_W-1:0]    frame_kind,
	output logic [sfd_pkg::LEN_W-1:0]     payload_size,
	output logic [sfd_pkg::LEFT_W-1:0]    bytes_to_go,
	output logic                          frame_end,
	output logic [sfd_pkg::CODE_W-1:0]    frame_status,
	input  logic                          cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfd_pkg::LEN_W-1:0]     cfg_data
);
	import sfd_pkg::*;

	sfd_cfg_t          cfg;
	sfd_result_t       result;
	sfd_result_t       held;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;

	// The byte in the input register moves on when the result stage can take it.
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	sfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfd_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.result  (result)
	);

	sfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.held      (held)
	);

	assign data_byte    = held.data_byte;
	assign byte_role    = held.byte_role;
	assign frame_kind   = held.frame_kind;
	assign payload_size = held.payload_size;
	assign bytes_to_go  = held.bytes_to_go;
	assign frame_end    = held.frame_end;
	assign frame_status = held.frame_status;

endmodule

@@ rtl/sfd_cfg_regs.sv @@
// Configuration register file of the serial frame deframer.
`timescale 1ns / 1ps
module sfd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfd_pkg::LEN_W-1:0]      cfg_data,
	output sfd_pkg::sfd_cfg_t              cfg
);
	import sfd_pkg::*;

	sfd_cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value <= '0;
			cfg_q.footer_value <= '0;
			cfg_q.type_limit   <= '1;
			cfg_q.max_payload  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_VALUE: cfg_q.header_value <= cfg_data[BYTE_W-1:0];
				CFG_FOOTER_VALUE: cfg_q.footer_value <= cfg_data[BYTE_W-1:0];
				CFG_TYPE_LIMIT:   cfg_q.type_limit   <= cfg_data[BYTE_W-1:0];
				CFG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/sfd_tracker.sv @@
// Frame layout tracker: phase state and per-byte result logic.
`timescale 1ns / 1ps
module sfd_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
	input  sfd_pkg::sfd_cfg_t           cfg,
	output sfd_pkg::sfd_result_t        result
);
	import sfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_TYPE,
		PH_PAYLOAD,
		PH_FOOTER
	} phase_t;

	localparam logic LAST_IDX = 1'(LEN_BYTES - 1);

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  length_accum_q, length_accum_d;
	logic              length_idx_q, length_idx_d;
	logic [BYTE_W-1:0] kind_q, kind_d;
	logic [LEN_W-1:0]  payload_count_q, payload_count_d;

	logic [LEN_W-1:0]  len_shifted;
	logic [LEN_W-1:0]  len_merged;
	logic [LEN_W-1:0]  count_dec;

	// Incoming length byte placed at its little-endian position.
	assign len_shifted = {{(LEN_W-BYTE_W){1'b0}}, rx_byte} << {length_idx_q, 3'b000};
	assign len_merged  = length_accum_q | len_shifted;
	assign count_dec   = (payload_count_q != '0) ? payload_count_q - LEN_W'(1) : payload_count_q;

	// Next state and the result for the byte in hand.
	always_comb begin
		phase_d         = phase_q;
		length_accum_d  = length_accum_q;
		length_idx_d    = length_idx_q;
		kind_d          = kind_q;
		payload_count_d = payload_count_q;
		result              = '0;
		result.data_byte    = rx_byte;

		unique case (phase_q)
			PH_LEN: begin
				result.byte_role = ROLE_LENGTH;
				length_accum_d   = len_merged;
				if (length_idx_q == LAST_IDX) begin
					result.payload_size = len_merged;
					if (len_merged > cfg.max_payload) begin
						result.frame_end    = 1'b1;
						result.frame_status = STAT_TOO_LONG;
						phase_d             = PH_HUNT;
					end else begin
						phase_d = PH_TYPE;
					end
				end else begin
					length_idx_d = 1'b1;
				end
			end
			PH_TYPE: begin
				result.byte_role    = ROLE_TYPE;
				result.frame_kind   = rx_byte;
				result.payload_size = length_accum_q;
				kind_d              = rx_byte;
				if (rx_byte >= cfg.type_limit) begin
					result.frame_end    = 1'b1;
					result.frame_status = STAT_BAD_TYPE;
					phase_d             = PH_HUNT;
				end else begin
					payload_count_d    = length_accum_q;
					result.bytes_to_go = {1'b0, length_accum_q} + LEFT_W'(1);
					phase_d = (length_accum_q == '0) ? PH_FOOTER : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				result.byte_role    = ROLE_PAYLOAD;
				result.frame_kind   = kind_q;
				result.payload_size = length_accum_q;
				payload_count_d     = count_dec;
				result.bytes_to_go  = {1'b0, count_dec} + LEFT_W'(1);
				if (count_dec == '0) begin
					phase_d = PH_FOOTER;
				end
			end
			PH_FOOTER: begin
				result.byte_role    = ROLE_FOOTER;
				result.frame_kind   = kind_q;
				result.payload_size = length_accum_q;
				result.frame_end    = 1'b1;
				result.frame_status = (rx_byte == cfg.footer_value) ? STAT_GOOD
				                                                     : STAT_BAD_FOOTER;
				phase_d             = PH_HUNT;
			end
			default: begin
				// Hunting: only a header byte opens a new frame.
				phase_d = PH_HUNT;
				if (rx_byte == cfg.header_value) begin
					result.byte_role = ROLE_HEADER;
					phase_d          = PH_LEN;
					length_accum_d   = '0;
					length_idx_d     = 1'b0;
					kind_d           = '0;
					payload_count_d  = '0;
				end
			end
		endcase
	end

	// State advances once per byte handed to the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			length_accum_q  <= '0;
			length_idx_q    <= 1'b0;
			kind_q          <= '0;
			payload_count_q <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			length_accum_q  <= length_accum_d;
			length_idx_q    <= length_idx_d;
			kind_q          <= kind_d;
			payload_count_q <= payload_count_d;
		end
	end

endmodule

@@ rtl/sfd_out_reg.sv @@
// Result register stage with valid and ready toward the consumer.
`timescale 1ns / 1ps
module sfd_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  sfd_pkg::sfd_result_t  result,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  free,
	output sfd_pkg::sfd_result_t  held
);
	import sfd_pkg::*;

	logic        valid_s2;
	sfd_result_t result_s2;

	// The stage can take a new result when empty or when its transaction completes.
	assign free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign held      = result_s2;

endmodule

@@ rtl/sfd_checker.sv @@
// Port-level assertions for the serial frame deframer, bound to the top level.
`timescale 1ns / 1ps
module sfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [sfd_pkg::BYTE_W-1:0]    data_byte,
	input logic [sfd_pkg::CODE_W-1:0]    byte_role,
	input logic [sfd_pkg::BYTE_W-1:0]    frame_kind,
	input logic [sfd_pkg::LEN_W-1:0]     payload_size,
	input logic [sfd_pkg::LEFT_W-1:0]    bytes_to_go,
	input logic                          frame_end,
	input logic [sfd_pkg::CODE_W-1:0]    frame_status
);
	import sfd_pkg::*;

	// A status is reported exactly on a byte that ends a frame.
	a_status_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == (frame_status != STAT_NONE)))
		else $error("frame_status and frame_end disagree");

	// Nothing remains to be received on a frame's last byte.
	a_end_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (bytes_to_go == '0))
		else $error("bytes_to_go nonzero on a frame end");

	// Discarded bytes carry no frame information.
	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_role == ROLE_DISCARD) |->
		(frame_kind == '0 && payload_size == '0 && bytes_to_go == '0 && !frame_end))
		else $error("discarded byte carries frame information");

	// A stalled result stays put until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(data_byte)
		&& $stable(byte_role) && $stable(bytes_to_go)))
		else $error("result changed while stalled");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.data_byte    (data_byte),
	.byte_role    (byte_role),
	.frame_kind   (frame_kind),
	.payload_size (payload_size),
	.bytes_to_go  (bytes_to_go),
	.frame_end    (frame_end),
	.frame_status (frame_status)
);
